// ----- hw/rtl/two_way_traffic_light_with_walk_request_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the traffic light controller
// Shared helpers that wrap concurrent assertions with the project clock/reset.
// ----------------------------------------------------------------------------
`ifndef TWO_WAY_TRAFFIC_LIGHT_WITH_WALK_REQUEST_TOP_ASSERT_SVH
`define TWO_WAY_TRAFFIC_LIGHT_WITH_WALK_REQUEST_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define TWL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("traffic light assertion failed");

// Next-cycle implication, disabled in reset
`define TWL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("traffic light assertion failed");

`endif

// ----- hw/rtl/twl_pkg.sv -----
// ----------------------------------------------------------------------------
// twl_pkg
// Types, lamp codes and walk sequence tables of the traffic light controller.
// ----------------------------------------------------------------------------
package twl_pkg;

    // Defaults for the top level parameters
    localparam int CD_SECONDS_DEF = 9;
    localparam int TICK_MS_DEF    = 500;

    // Lamp bits, lowest bit first
    localparam logic [7:0] L_ER = 8'h01;
    localparam logic [7:0] L_EY = 8'h02;
    localparam logic [7:0] L_EG = 8'h04;
    localparam logic [7:0] L_EW = 8'h08;
    localparam logic [7:0] L_NR = 8'h10;
    localparam logic [7:0] L_NY = 8'h20;
    localparam logic [7:0] L_NG = 8'h40;
    localparam logic [7:0] L_NW = 8'h80;

    // Configuration register indexes (word address)
    localparam logic [1:0] REG_GREEN  = 2'd0;
    localparam logic [1:0] REG_YELLOW = 2'd1;
    localparam logic [1:0] REG_RED    = 2'd2;

    // Signal phases
    typedef enum logic [5:0] {
        PH_EG    = 6'b000001,  // EW green, NS red
        PH_EY    = 6'b000010,  // EW yellow, NS red
        PH_RED_A = 6'b000100,  // all red
        PH_NG    = 6'b001000,  // EW red, NS green
        PH_NY    = 6'b010000,  // EW red, NS yellow
        PH_RED_B = 6'b100000   // all red
    } phase_t;

    // Segment durations
    typedef enum logic [2:0] {
        MS_0,
        MS_1000,
        MS_1500,
        MS_2000,
        MS_5000
    } ms_t;

    typedef struct packed {
        logic [7:0] lamps;
        ms_t        ms;
    } pre_seg_t;

    // One decoded walk segment
    typedef struct packed {
        logic       valid;
        logic [7:0] lamp_clr;
        logic [7:0] lamp_set;
        logic [5:0] ticks;
        logic [3:0] secs;
    } seg_t;

    typedef struct packed {
        logic [5:0] green_len;
        logic [5:0] yellow_len;
        logic [5:0] red_len;
    } cfg_t;

    // Phase to table row; unknown codes act as the last all-red phase
    function automatic logic [2:0] ph_idx(input phase_t ph);
        logic [2:0] r;
        unique case (ph)
            PH_EG:    r = 3'd0;
            PH_EY:    r = 3'd1;
            PH_RED_A: r = 3'd2;
            PH_NG:    r = 3'd3;
            PH_NY:    r = 3'd4;
            default:  r = 3'd5;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] phase_lamps(input phase_t ph);
        logic [7:0] r;
        unique case (ph)
            PH_EG:    r = L_EG | L_NR;
            PH_EY:    r = L_EY | L_NR;
            PH_RED_A: r = L_ER | L_NR;
            PH_NG:    r = L_ER | L_NG;
            PH_NY:    r = L_ER | L_NY;
            default:  r = L_ER | L_NR;
        endcase
        return r;
    endfunction

    // Prefix length; br = 0 second road branch, 1 first road branch
    function automatic logic [2:0] pre_len(input logic [2:0] p, input logic br);
        logic [2:0] r;
        case ({p, br})
            4'b000_0: r = 3'd1;
            4'b000_1: r = 3'd2;
            4'b001_0: r = 3'd4;
            4'b001_1: r = 3'd2;
            4'b010_0: r = 3'd3;
            4'b010_1: r = 3'd2;
            4'b011_0: r = 3'd3;
            4'b011_1: r = 3'd1;
            4'b100_0: r = 3'd2;
            4'b100_1: r = 3'd4;
            4'b101_0: r = 3'd2;
            default:  r = 3'd4;
        endcase
        return r;
    endfunction

    // Prefix segment table, keyed by {row, branch, segment}
    function automatic pre_seg_t pre_entry(input logic [2:0] p, input logic br,
                                           input logic [1:0] i);
        pre_seg_t r;
        case ({p, br, i})
            6'b000_0_00: r = '{L_EG | L_NR | L_NW, MS_5000};
            6'b000_1_00: r = '{L_EY | L_NR,        MS_2000};
            6'b000_1_01: r = '{L_ER | L_NG | L_EW, MS_5000};
            6'b001_0_00: r = '{L_EY | L_NR,        MS_1500};
            6'b001_0_01: r = '{L_ER | L_NG | L_NW, MS_2000};
            6'b001_0_10: r = '{L_ER | L_NY | L_NW, MS_2000};
            6'b001_0_11: r = '{L_EG | L_NR | L_NW, MS_0};
            6'b001_1_00: r = '{L_EY | L_NR,        MS_1500};
            6'b001_1_01: r = '{L_ER | L_NG | L_EW, MS_5000};
            6'b010_0_00: r = '{L_ER | L_NG | L_NW, MS_2000};
            6'b010_0_01: r = '{L_ER | L_NY | L_NW, MS_2000};
            6'b010_0_10: r = '{L_EG | L_NR | L_NW, MS_2000};
            6'b010_1_00: r = '{L_ER | L_NR | L_EW, MS_2000};
            6'b010_1_01: r = '{L_ER | L_NG | L_EW, MS_2000};
            6'b011_0_00: r = '{L_ER | L_NG,        MS_2000};
            6'b011_0_01: r = '{L_ER | L_NY,        MS_2000};
            6'b011_0_10: r = '{L_EG | L_NR | L_NW, MS_2000};
            6'b011_1_00: r = '{L_ER | L_NG | L_EW, MS_2000};
            6'b100_0_00: r = '{L_ER | L_NY | L_NW, MS_2000};
            6'b100_0_01: r = '{L_EG | L_NR | L_NW, MS_2000};
            6'b100_1_00: r = '{L_ER | L_NY | L_EW, MS_1000};
            6'b100_1_01: r = '{L_EG | L_NR | L_EW, MS_2000};
            6'b100_1_10: r = '{L_EY | L_NR | L_EW, MS_2000};
            6'b100_1_11: r = '{L_ER | L_NG | L_EW, MS_1000};
            6'b101_0_00: r = '{L_ER | L_NR | L_NW, MS_1000};
            6'b101_0_01: r = '{L_EG | L_NR | L_NW, MS_1000};
            6'b101_1_00: r = '{L_ER | L_NR | L_EW, MS_1000};
            6'b101_1_01: r = '{L_EG | L_NR | L_EW, MS_2000};
            6'b101_1_10: r = '{L_EY | L_NR | L_EW, MS_2000};
            6'b101_1_11: r = '{L_ER | L_NG | L_EW, MS_1000};
            default:     r = '{8'h00, MS_0};
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/twl_seq.sv -----
// ----------------------------------------------------------------------------
// twl_seq
// Walk sequence decoder: lamp change, length and countdown of one segment.
// ----------------------------------------------------------------------------
module twl_seq
    import twl_pkg::*;
#(
    parameter int COUNTDOWN_SECONDS = CD_SECONDS_DEF,
    parameter int TICK_MS           = TICK_MS_DEF
)
(
    input  phase_t     phase,
    input  logic       req_ew,
    input  logic       req_ns,
    input  logic [7:0] idx,
    output seg_t       seg
);

    localparam int NC    = 2 * COUNTDOWN_SECONDS;
    localparam int R1000 = (1000 + TICK_MS / 2) / TICK_MS;
    localparam int R1500 = (1500 + TICK_MS / 2) / TICK_MS;
    localparam int R2000 = (2000 + TICK_MS / 2) / TICK_MS;
    localparam int R5000 = (5000 + TICK_MS / 2) / TICK_MS;
    localparam logic [5:0] T1000 = 6'((R1000 == 0) ? 1 : R1000);
    localparam logic [5:0] T1500 = 6'((R1500 == 0) ? 1 : R1500);
    localparam logic [5:0] T2000 = 6'((R2000 == 0) ? 1 : R2000);
    localparam logic [5:0] T5000 = 6'((R5000 == 0) ? 1 : R5000);

    logic [2:0] row;
    logic       br;
    logic [2:0] np;
    logic [7:0] j;
    logic [7:0] k;
    pre_seg_t   pe;
    logic [7:0] wbit;
    logic [5:0] pre_ticks;

    // Prefix lookup
    always_comb
    begin
        row  = ph_idx(phase);
        br   = ~req_ns;
        np   = pre_len(row, br);
        pe   = pre_entry(row, br, idx[1:0]);
        j    = idx - {5'd0, np};
        k    = j - 8'(NC);
        wbit = req_ew ? L_EW : L_NW;
        case (pe.ms)
            MS_1000: pre_ticks = T1000;
            MS_1500: pre_ticks = T1500;
            MS_2000: pre_ticks = T2000;
            MS_5000: pre_ticks = T5000;
            default: pre_ticks = 6'd0;
        endcase
    end

    // Segment select: prefix, blinking countdown, first-road tail
    always_comb
    begin
        seg = '0;
        if (idx < {5'd0, np})
        begin
            seg.valid    = 1'b1;
            seg.lamp_clr = 8'hFF;
            seg.lamp_set = pe.lamps;
            seg.ticks    = pre_ticks;
        end
        else if (j < 8'(NC))
        begin
            seg.valid    = 1'b1;
            seg.lamp_clr = j[0] ? 8'h00 : wbit;
            seg.lamp_set = j[0] ? wbit : 8'h00;
            seg.ticks    = T1000;
            seg.secs     = 4'(COUNTDOWN_SECONDS) - j[4:1];
        end
        else if (req_ew && (k < 8'd3))
        begin
            seg.valid = 1'b1;
            case (k[1:0])
                2'd0:
                begin
                    seg.ticks = T1000;
                end
                2'd1:
                begin
                    seg.lamp_clr = L_EW | L_NG;
                    seg.lamp_set = L_NY;
                    seg.ticks    = T2000;
                end
                default:
                begin
                    seg.lamp_clr = L_NY;
                    seg.lamp_set = L_NR;
                    seg.ticks    = T2000;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/twl_ctrl.sv -----
// ----------------------------------------------------------------------------
// twl_ctrl
// Phase and walk sequencer: advances one tick per accepted request.
// ----------------------------------------------------------------------------
`include "two_way_traffic_light_with_walk_request_top_assert.svh"

module twl_ctrl
    import twl_pkg::*;
#(
    parameter int COUNTDOWN_SECONDS = CD_SECONDS_DEF,
    parameter int TICK_MS           = TICK_MS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       ev_ew,
    input  logic       ev_ns,
    input  cfg_t       cfg,
    output logic [7:0] lamps,
    output logic [3:0] countdown
);

    phase_t     phase_reg, phase_next;
    phase_t     int_phase_reg, int_phase_next;
    logic [5:0] phase_ticks_reg, phase_ticks_next;
    logic [5:0] seg_ticks_reg, seg_ticks_next;
    logic       walk_active_reg, walk_active_next;
    logic [7:0] walk_step_reg, walk_step_next;
    logic       req_ew_reg, req_ew_next;
    logic       req_ns_reg, req_ns_next;
    logic [7:0] lamp_reg, lamp_next;
    logic [3:0] countdown_reg, countdown_next;

    logic       req_ew_new;
    logic       req_ns_new;
    logic       start;
    logic [5:0] tick_inc;
    logic [5:0] limit;
    phase_t     phase_succ;
    phase_t     seq_phase;
    logic [7:0] seg_idx;
    logic [7:0] seg_idx_1;
    seg_t       seg_a;
    seg_t       seg_b;
    logic [7:0] lamp_a;

    // Requests latch only outside a walk
    assign req_ew_new = req_ew_reg | (ev_ew & ~walk_active_reg);
    assign req_ns_new = req_ns_reg | (ev_ns & ~walk_active_reg);
    assign start      = ~walk_active_reg & (req_ew_new | req_ns_new);
    assign tick_inc   = phase_ticks_reg + 6'd1;

    // Segment to enter and the one after it (zero-length chaining)
    assign seq_phase = walk_active_reg ? int_phase_reg : phase_reg;
    assign seg_idx   = walk_active_reg ? (walk_step_reg + 8'd1) : 8'd0;
    assign seg_idx_1 = seg_idx + 8'd1;

    twl_seq #(
        .COUNTDOWN_SECONDS (COUNTDOWN_SECONDS),
        .TICK_MS           (TICK_MS)
    ) u_seq_a (
        .phase  (seq_phase),
        .req_ew (req_ew_new),
        .req_ns (req_ns_new),
        .idx    (seg_idx),
        .seg    (seg_a)
    );

    twl_seq #(
        .COUNTDOWN_SECONDS (COUNTDOWN_SECONDS),
        .TICK_MS           (TICK_MS)
    ) u_seq_b (
        .phase  (seq_phase),
        .req_ew (req_ew_new),
        .req_ns (req_ns_new),
        .idx    (seg_idx_1),
        .seg    (seg_b)
    );

    assign lamp_a = (lamp_reg & ~seg_a.lamp_clr) | seg_a.lamp_set;

    // Phase length and successor
    always_comb
    begin
        unique case (phase_reg) inside
            PH_EG, PH_NG: limit = cfg.green_len;
            PH_EY:        limit = cfg.yellow_len;
            default:      limit = cfg.red_len;
        endcase
        unique case (phase_reg)
            PH_EG:    phase_succ = PH_EY;
            PH_EY:    phase_succ = PH_RED_A;
            PH_RED_A: phase_succ = PH_NG;
            PH_NG:    phase_succ = PH_NY;
            PH_NY:    phase_succ = PH_RED_B;
            default:  phase_succ = PH_EG;
        endcase
    end

    // Next state
    always_comb
    begin
        phase_next       = phase_reg;
        int_phase_next   = int_phase_reg;
        phase_ticks_next = phase_ticks_reg;
        seg_ticks_next   = seg_ticks_reg;
        walk_active_next = walk_active_reg;
        walk_step_next   = walk_step_reg;
        req_ew_next      = req_ew_reg;
        req_ns_next      = req_ns_reg;
        lamp_next        = lamp_reg;
        countdown_next   = countdown_reg;

        if (accept)
        begin
            req_ew_next = req_ew_new;
            req_ns_next = req_ns_new;
            if (walk_active_reg || start)
            begin
                phase_ticks_next = tick_inc;
                if (start)
                begin
                    int_phase_next   = phase_reg;
                    walk_active_next = 1'b1;
                end
                if (start || (tick_inc >= seg_ticks_reg))
                begin
                    phase_ticks_next = 6'd0;
                    if (seg_a.valid && (seg_a.ticks != 6'd0))
                    begin
                        lamp_next      = lamp_a;
                        countdown_next = seg_a.secs;
                        walk_step_next = seg_idx;
                        seg_ticks_next = seg_a.ticks;
                    end
                    else if (seg_a.valid && seg_b.valid)
                    begin
                        lamp_next      = (lamp_a & ~seg_b.lamp_clr) | seg_b.lamp_set;
                        countdown_next = seg_b.secs;
                        walk_step_next = seg_idx_1;
                        seg_ticks_next = seg_b.ticks;
                    end
                    else
                    begin
                        // Sequence done: restart at phase one
                        walk_active_next = 1'b0;
                        walk_step_next   = 8'd0;
                        req_ew_next      = 1'b0;
                        req_ns_next      = 1'b0;
                        countdown_next   = 4'd0;
                        phase_next       = PH_EG;
                        lamp_next        = phase_lamps(PH_EG);
                    end
                end
            end
            else if (phase_ticks_reg >= limit)
            begin
                phase_next       = phase_succ;
                phase_ticks_next = 6'd0;
                lamp_next        = phase_lamps(phase_succ);
            end
            else
            begin
                phase_ticks_next = tick_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_EG;
            int_phase_reg   <= PH_EG;
            phase_ticks_reg <= 6'd0;
            seg_ticks_reg   <= 6'd1;
            walk_active_reg <= 1'b0;
            walk_step_reg   <= 8'd0;
            req_ew_reg      <= 1'b0;
            req_ns_reg      <= 1'b0;
            lamp_reg        <= L_EG | L_NR;
            countdown_reg   <= 4'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            int_phase_reg   <= int_phase_next;
            phase_ticks_reg <= phase_ticks_next;
            seg_ticks_reg   <= seg_ticks_next;
            walk_active_reg <= walk_active_next;
            walk_step_reg   <= walk_step_next;
            req_ew_reg      <= req_ew_next;
            req_ns_reg      <= req_ns_next;
            lamp_reg        <= lamp_next;
            countdown_reg   <= countdown_next;
        end
    end

    assign lamps     = lamp_reg;
    assign countdown = countdown_reg;

    // Checks
    `TWL_ASSERT_IMP(a_cd_idle, clk, rst_n, !walk_active_reg, countdown_reg == 4'd0)
    `TWL_ASSERT_IMP(a_seg_len, clk, rst_n, walk_active_reg, seg_ticks_reg != 6'd0)
    `TWL_ASSERT_NXT(a_hold, clk, rst_n, !accept, $stable(lamp_reg) && $stable(walk_step_reg))

endmodule

// ----- hw/rtl/two_way_traffic_light_with_walk_request_top.sv -----
// ----------------------------------------------------------------------------
// two_way_traffic_light_with_walk_request_top
// Two-road traffic light controller with pedestrian walk requests.
// ----------------------------------------------------------------------------
// Each stream request is one tick of TICK_MS ms carrying the two walk button
// events; the block returns one result per tick with the lamps and countdown
// shown during that tick. Six phases run for their register value plus one
// tick; a latched walk request plays a fixed sequence, a blinking countdown from
// COUNTDOWN_SECONDS seconds to one and, for a first-road request, a clearing tail.
// Throughput is one tick per clock while m_tready is high: the phase/walk
// sequencer updates in a single pass, a result enters the output register
// in the cycle after its tick is taken, while the next tick can be accepted.
`include "two_way_traffic_light_with_walk_request_top_assert.svh"

module two_way_traffic_light_with_walk_request_top
    import twl_pkg::*;
#(
    parameter int COUNTDOWN_SECONDS = CD_SECONDS_DEF,
    parameter int TICK_MS           = TICK_MS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Tick requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] button_ew_event, [1] button_ns_event, [7:2] zero
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] ew_red, [1] ew_yellow, [2] ew_green, [3] ew_walk,
                                   // [4] ns_red, [5] ns_yellow, [6] ns_green, [7] ns_walk,
                                   // [11:8] seconds_left, [15:12] zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t        cfg_reg;
    logic        cfg_wr;
    logic        accept;
    logic [7:0]  lamps;
    logic [3:0]  countdown;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.green_len  <= 6'd5;
            cfg_reg.yellow_len <= 6'd3;
            cfg_reg.red_len    <= 6'd5;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_GREEN:  cfg_reg.green_len  <= pwdata[5:0];
                REG_YELLOW: cfg_reg.yellow_len <= pwdata[5:0];
                REG_RED:    cfg_reg.red_len    <= pwdata[5:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_GREEN:  prdata = {26'd0, cfg_reg.green_len};
            REG_YELLOW: prdata = {26'd0, cfg_reg.yellow_len};
            REG_RED:    prdata = {26'd0, cfg_reg.red_len};
            default:    prdata = 32'd0;
        endcase
    end

    // Sequencer
    assign s_tready = ~m_tvalid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;

    twl_ctrl #(
        .COUNTDOWN_SECONDS (COUNTDOWN_SECONDS),
        .TICK_MS           (TICK_MS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ev_ew     (s_tdata[0]),
        .ev_ns     (s_tdata[1]),
        .cfg       (cfg_reg),
        .lamps     (lamps),
        .countdown (countdown)
    );

    // Result register
    assign m_tvalid_next = accept | (m_tvalid_reg & ~m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {4'd0, countdown, lamps};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `TWL_ASSERT_NXT(a_out_load, clk, rst_n, s_tvalid && s_tready, m_tvalid)

endmodule
